FILE: design/assert_macros.svh
// Assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define FLPTM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a plain condition on every rising clock edge outside reset.
`define FLPTM_CHECK(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

FILE: design/flptm_pkg.sv
// Shared types, codes and constants of the page table mapper.
`default_nettype none
package flptm_pkg;

    localparam int POOL_TABLES_DEF = 64;
    localparam int TABLE_ENTRIES   = 512;
    localparam int SLOT_W          = 9;
    localparam int PAGE_SHIFT      = 12;
    localparam int VPN_W           = 36;
    localparam int PPN_W           = 40;

    localparam logic [63:0] ADDR_FIELD = 64'h000F_FFFF_FFFF_F000;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_UNALIGNED = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_UNUSED    = 2'd3;

    localparam logic KIND_MAP  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        OP_MAP,
        OP_READ,
        OP_BAD
    } op_t;

    typedef struct packed {
        logic        kind;
        logic [47:0] virt_addr;
        logic [51:0] phys_addr;
        logic [19:0] page_count;
        logic [15:0] flags;
        logic [5:0]  table_index;
        logic [8:0]  entry_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] entry_value;
        logic [6:0]  tables_in_use;
    } res_t;

    // Classified item passed from the front to the back.
    typedef struct packed {
        op_t               op;
        logic [VPN_W-1:0]  vpn;
        logic [PPN_W-1:0]  ppn;
        logic [19:0]       page_count;
        logic [15:0]       flags;
        logic [5:0]        table_index;
        logic [8:0]        entry_index;
    } work_t;

    // Back status seen by the front.
    typedef struct packed {
        logic clearing;
    } back_stat_t;

    // Build a table entry from an address and flag bits.
    function automatic logic [63:0] make_entry(input logic [51:0] addr,
                                               input logic [15:0] flags);
        make_entry = ({12'd0, addr} & ADDR_FIELD) | 64'd1 | {48'd0, flags};
    endfunction

endpackage
`default_nettype wire

FILE: design/four_level_page_table_mapper_unit.sv
// Top level of the four-level page table mapper.
// After reset the block sweeps its table store to zero with busy high. A read
// item reads one table entry and then gives its result. For each page a map
// item starts the page, walks or builds the three table levels, each with a
// read, a check and a compare step, and then writes the leaf entry. A map that
// runs out of tables returns early; an unaligned map returns without a walk.
// The entry read at each level depends on the level before. Results appear on
// result for one cycle with done high, in acceptance order, and must be taken
// then: the receiver cannot stall. Two items can wait in the queue.
`default_nettype none
module four_level_page_table_mapper_unit #(
    parameter int POOL_TABLES = flptm_pkg::POOL_TABLES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire flptm_pkg::cmd_t  cmd,
    output logic                  done,
    output flptm_pkg::res_t       result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [51:0]      cfg_data
);
    import flptm_pkg::*;

    logic       push, queue_full, queue_avail, pop;
    work_t      push_item, head_item;
    back_stat_t back_stat;

    assign cfg_ready = 1'b1;

    flptm_front u_front (
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .back_stat  (back_stat),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    flptm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .not_empty (queue_avail),
        .pop       (pop),
        .head_item (head_item)
    );

    flptm_back #(
        .POOL_TABLES (POOL_TABLES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_data   (cfg_data),
        .item_avail (queue_avail),
        .item       (head_item),
        .pop        (pop),
        .back_stat  (back_stat),
        .done       (done),
        .result     (result)
    );
endmodule
`default_nettype wire

FILE: design/flptm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module flptm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word and read one word into the registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: design/flptm_queue.sv
// Two-entry queue between the front and the back.
`default_nettype none
module flptm_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire flptm_pkg::work_t push_item,
    output logic                  full,
    output logic                  not_empty,
    input  wire logic             pop,
    output flptm_pkg::work_t      head_item
);
    import flptm_pkg::*;

    work_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head_item = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

FILE: design/flptm_front.sv
// Front end: accepts commands and classifies them for the back end.
`default_nettype none
module flptm_front (
    input  wire logic                  start,
    output logic                       busy,
    input  wire flptm_pkg::cmd_t       cmd,
    input  wire flptm_pkg::back_stat_t back_stat,
    input  wire logic                  queue_full,
    output logic                       push,
    output flptm_pkg::work_t           push_item
);
    import flptm_pkg::*;

    logic unaligned;

    assign busy      = queue_full | back_stat.clearing;
    assign push      = start & ~busy;
    assign unaligned = (cmd.virt_addr[PAGE_SHIFT-1:0] != '0) ||
                       (cmd.phys_addr[PAGE_SHIFT-1:0] != '0);

    // Classify the item and split off page numbers
    always_comb
    begin
        push_item.vpn         = cmd.virt_addr[47:PAGE_SHIFT];
        push_item.ppn         = cmd.phys_addr[51:PAGE_SHIFT];
        push_item.page_count  = cmd.page_count;
        push_item.flags       = cmd.flags;
        push_item.table_index = cmd.table_index;
        push_item.entry_index = cmd.entry_index;
        if (cmd.kind == KIND_READ)
        begin
            push_item.op = OP_READ;
        end
        else if (unaligned)
        begin
            push_item.op = OP_BAD;
        end
        else
        begin
            push_item.op = OP_MAP;
        end
    end
endmodule
`default_nettype wire

FILE: design/flptm_back.sv
// Back end: walks and builds the tables, serves reads, issues results.
`default_nettype none
module flptm_back #(
    parameter int POOL_TABLES = flptm_pkg::POOL_TABLES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [51:0]           cfg_data,
    input  wire logic                  item_avail,
    input  wire flptm_pkg::work_t      item,
    output logic                       pop,
    output flptm_pkg::back_stat_t      back_stat,
    output logic                       done,
    output flptm_pkg::res_t            result
);
    import flptm_pkg::*;

    localparam int TW    = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int CW    = $clog2(POOL_TABLES + 1);
    localparam int AW    = TW + SLOT_W;
    localparam int DEPTH = POOL_TABLES * TABLE_ENTRIES;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_PG_START,
        S_LV_RD,
        S_LV_CHK,
        S_LV_CMP,
        S_LEAF,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [51:0]       base_reg, base_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [CW-1:0]     alloc_reg, alloc_next;
    logic [VPN_W-1:0]  vpn_reg, vpn_next;
    logic [PPN_W-1:0]  ppn_reg, ppn_next;
    logic [19:0]       remain_reg, remain_next;
    logic [15:0]       flags_reg, flags_next;
    logic [1:0]        level_reg, level_next;
    logic [TW-1:0]     cur_reg, cur_next;
    logic [39:0]       diff_reg, diff_next;
    logic              present_reg, present_next;
    logic [51:0]       new_addr_reg, new_addr_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [1:0]        status_reg, status_next;
    logic              done_reg, done_next;
    res_t              result_reg, result_next;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [63:0]       mem_wdata, mem_rdata;
    logic [SLOT_W-1:0] slot;
    logic [51:0]       base_field;
    logic [51:0]       entry_diff;

    flptm_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign back_stat.clearing = (state_reg == S_CLEAR);
    assign done               = done_reg;
    assign result             = result_reg;
    assign base_field         = {base_reg[51:PAGE_SHIFT], 12'd0};
    assign entry_diff         = mem_rdata[51:0] - base_field;

    // Pick the slot that indexes the table at the current level
    always_comb
    begin
        case (level_reg)
            2'd3:    slot = vpn_reg[35:27];
            2'd2:    slot = vpn_reg[26:18];
            2'd1:    slot = vpn_reg[17:9];
            default: slot = vpn_reg[8:0];
        endcase
    end

    // Sequence table walks, allocations and reads
    always_comb
    begin
        state_next    = state_reg;
        base_next     = cfg_we ? cfg_data : base_reg;
        clr_next      = clr_reg;
        alloc_next    = alloc_reg;
        vpn_next      = vpn_reg;
        ppn_next      = ppn_reg;
        remain_next   = remain_reg;
        flags_next    = flags_reg;
        level_next    = level_reg;
        cur_next      = cur_reg;
        diff_next     = diff_reg;
        present_next  = present_reg;
        new_addr_next = new_addr_reg;
        rd_ok_next    = rd_ok_reg;
        status_next   = status_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        pop           = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = {cur_reg, slot};
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = {cur_reg, slot};

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_avail)
                begin
                    pop         = 1'b1;
                    vpn_next    = item.vpn;
                    ppn_next    = item.ppn;
                    remain_next = item.page_count;
                    flags_next  = item.flags;
                    status_next = ST_DONE;
                    unique case (item.op)
                        OP_READ:
                        begin
                            rd_ok_next = ({7'd0, item.table_index} < 13'(POOL_TABLES));
                            mem_re     = 1'b1;
                            mem_raddr  = AW'({item.table_index, item.entry_index});
                            state_next = S_RD_WAIT;
                        end
                        OP_BAD:
                        begin
                            status_next = ST_UNALIGNED;
                            state_next  = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_PG_START;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                done_next                 = 1'b1;
                result_next.status        = ST_DONE;
                result_next.entry_value   = rd_ok_reg ? mem_rdata : 64'd0;
                result_next.tables_in_use = 7'(alloc_reg);
                state_next                = S_IDLE;
            end
            S_PG_START:
            begin
                level_next = 2'd3;
                cur_next   = '0;
                state_next = (remain_reg == '0) ? S_DONE : S_LV_RD;
            end
            S_LV_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_LV_CHK;
            end
            S_LV_CHK:
            begin
                present_next  = mem_rdata[0];
                diff_next     = entry_diff[51:PAGE_SHIFT];
                new_addr_next = base_field + {(52 - CW - PAGE_SHIFT)'(0), alloc_reg, 12'd0};
                state_next    = S_LV_CMP;
            end
            S_LV_CMP:
            begin
                if (present_reg && (diff_reg < 40'(alloc_reg)))
                begin
                    cur_next   = diff_reg[TW-1:0];
                    level_next = level_reg - 2'd1;
                    state_next = (level_reg == 2'd1) ? S_LEAF : S_LV_RD;
                end
                else if (alloc_reg >= CW'(POOL_TABLES))
                begin
                    status_next = ST_EXHAUSTED;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = make_entry(new_addr_reg, flags_reg);
                    cur_next   = alloc_reg[TW-1:0];
                    alloc_next = alloc_reg + 1'b1;
                    level_next = level_reg - 2'd1;
                    state_next = (level_reg == 2'd1) ? S_LEAF : S_LV_RD;
                end
            end
            S_LEAF:
            begin
                mem_we      = 1'b1;
                mem_wdata   = make_entry({ppn_reg, 12'd0}, flags_reg);
                vpn_next    = vpn_reg + 1'b1;
                ppn_next    = ppn_reg + 1'b1;
                remain_next = remain_reg - 1'b1;
                state_next  = S_PG_START;
            end
            S_DONE:
            begin
                done_next                 = 1'b1;
                result_next.status        = status_reg;
                result_next.entry_value   = 64'd0;
                result_next.tables_in_use = 7'(alloc_reg);
                state_next                = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state, the pool base and the done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            base_reg  <= '0;
            clr_reg   <= '0;
            alloc_reg <= CW'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            clr_reg   <= clr_next;
            alloc_reg <= alloc_next;
            done_reg  <= done_next;
        end
    end

    // Hold walk payload
    always_ff @(posedge clk)
    begin
        vpn_reg      <= vpn_next;
        ppn_reg      <= ppn_next;
        remain_reg   <= remain_next;
        flags_reg    <= flags_next;
        level_reg    <= level_next;
        cur_reg      <= cur_next;
        diff_reg     <= diff_next;
        present_reg  <= present_next;
        new_addr_reg <= new_addr_next;
        rd_ok_reg    <= rd_ok_next;
        status_reg   <= status_next;
        result_reg   <= result_next;
    end
endmodule
`default_nettype wire

FILE: design/flptm_checker.sv
// Port-level checker for the page table mapper, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module flptm_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            busy,
    input wire logic            done,
    input wire flptm_pkg::res_t result
);
    import flptm_pkg::*;

    `FLPTM_ASSERT(a_done_pulse, clk, rst_n, done |=> !done, "results closer than two cycles")
    `FLPTM_CHECK(a_status_code, clk, rst_n, !done || (result.status != ST_UNUSED), "bad status")
    `FLPTM_CHECK(a_fail_zero, clk, rst_n, !done || (result.status == ST_DONE) || (result.entry_value == 64'd0), "failed map carries value")
    `FLPTM_ASSERT(a_busy_reset, clk, rst_n, $rose(rst_n) |-> busy, "busy low during clear")
endmodule

bind four_level_page_table_mapper_unit flptm_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire

FILE: bench/four_level_page_table_mapper_unit_tb.sv
// Self-checking testbench for the four-level page table mapper unit.
`timescale 1ns / 100ps
`default_nettype none
module four_level_page_table_mapper_unit_tb;
    import flptm_pkg::*;

    localparam int NUM_TABLES = 64;
    localparam int STALL_LIMIT = 200000;
    localparam logic [63:0] MASK52 = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [51:0] POOL_MAX = 52'hF_FFFF_FFFF_FFFF;
    localparam logic [19:0] COUNT_MAX = 20'hF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    res_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [51:0] cfg_data;

    // Shadow page tables and allocation state
    logic [63:0] shadow_tables [0:NUM_TABLES*TABLE_ENTRIES-1];
    int          tables_used;
    logic [51:0] shadow_pool_base;

    res_t        pending_results [$];
    int          errors;
    int          idle_cycles;
    bit          gaps_on;
    logic [47:0] region_base [4];

    four_level_page_table_mapper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Build an entry from the page address bits and the flags
    function automatic logic [63:0] pte_of(input logic [51:0] addr, input logic [15:0] fl);
        pte_of = {12'd0, addr[51:12], 12'd0} | 64'd1 | {48'd0, fl};
    endfunction

    // Pool table number selected by an entry's address field
    function automatic logic [63:0] table_of(input logic [63:0] e);
        logic [63:0] off;
        off = ((e & ADDR_FIELD) - ({12'd0, shadow_pool_base} & ADDR_FIELD)) & MASK52;
        table_of = off >> 12;
    endfunction

    // Find or allocate the next-level table; return 0 when the pool is out
    function automatic bit descend_level(input int cur, input logic [8:0] slot,
                                         input logic [15:0] fl, output int nxt);
        int          pos;
        logic [63:0] e;
        logic [63:0] t;
        logic [63:0] taddr;
        pos = cur * TABLE_ENTRIES + slot;
        e = shadow_tables[pos];
        t = table_of(e);
        if (e[0] && t < tables_used) begin
            nxt = int'(t);
            return 1;
        end
        if (tables_used >= NUM_TABLES)
            return 0;
        nxt = tables_used;
        tables_used++;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            shadow_tables[nxt*TABLE_ENTRIES + i] = '0;
        taddr = (({12'd0, shadow_pool_base} & ADDR_FIELD) + (64'(nxt) << 12)) & MASK52;
        shadow_tables[pos] = pte_of(taddr[51:0], fl);
        return 1;
    endfunction

    // True when the first page of a map at v would need a table that cannot be had
    function automatic bit first_page_blocked(input logic [47:0] v);
        int          cur;
        logic [63:0] e;
        logic [63:0] t;
        if (tables_used < NUM_TABLES)
            return 0;
        cur = 0;
        for (int lvl = 3; lvl >= 1; lvl--) begin
            e = shadow_tables[cur*TABLE_ENTRIES + v[12 + 9*lvl +: 9]];
            t = table_of(e);
            if (!e[0] || t >= tables_used)
                return 1;
            cur = int'(t);
        end
        return 0;
    endfunction

    // Expected result of one item, updating the shadow tables
    function automatic res_t predict_mapping(input cmd_t c);
        res_t        r;
        logic [47:0] pv;
        logic [51:0] pp;
        int          t3, t2, t1;
        r = '0;
        if (c.kind == KIND_READ) begin
            if (c.table_index < NUM_TABLES)
                r.entry_value = shadow_tables[c.table_index*TABLE_ENTRIES + c.entry_index];
        end else if (c.virt_addr[11:0] != 0 || c.phys_addr[11:0] != 0) begin
            r.status = ST_UNALIGNED;
        end else begin
            for (int j = 0; j < c.page_count; j++) begin
                pv = c.virt_addr + (48'(j) << 12);
                pp = c.phys_addr + (52'(j) << 12);
                if (!descend_level(0, pv[47:39], c.flags, t3) ||
                    !descend_level(t3, pv[38:30], c.flags, t2) ||
                    !descend_level(t2, pv[29:21], c.flags, t1)) begin
                    r.status = ST_EXHAUSTED;
                    break;
                end
                shadow_tables[t1*TABLE_ENTRIES + pv[20:12]] = pte_of(pp, c.flags);
            end
        end
        r.tables_in_use = 7'(tables_used);
        return r;
    endfunction

    // Track config writes
    always @(posedge clk) begin
        if (rst_n && cfg_valid && cfg_ready)
            shadow_pool_base <= cfg_data;
    end

    // Compare each result with the oldest expectation
    always @(posedge clk) begin
        res_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %p", result);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (result.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, result.status);
                    errors++;
                end
                if (result.entry_value !== want.entry_value) begin
                    $error("entry_value expected %h actual %h",
                           want.entry_value, result.entry_value);
                    errors++;
                end
                if (result.tables_in_use !== want.tables_in_use) begin
                    $error("tables_in_use expected %0d actual %0d",
                           want.tables_in_use, result.tables_in_use);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with nothing accepted or returned
    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("four_level_page_table_mapper_unit_tb: FAIL");
            $finish;
        end
    end

    // Offer one item; predict it at the edge that accepts it and return there
    task automatic send_item(input cmd_t c);
        if (gaps_on && $urandom_range(99) < 11) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do @(negedge clk); while (busy);
        @(posedge clk);
        pending_results.push_back(predict_mapping(c));
    endtask

    task automatic hold_off();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Drain, then write the pool base
    task automatic set_pool_base(input logic [51:0] value);
        hold_off();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic cmd_t map_cmd(input logic [47:0] v, input logic [51:0] p,
                                     input logic [19:0] n, input logic [15:0] fl);
        cmd_t c;
        c = '0;
        c.kind = KIND_MAP;
        c.virt_addr = v;
        c.phys_addr = p;
        c.page_count = n;
        c.flags = fl;
        return c;
    endfunction

    function automatic cmd_t read_cmd(input logic [5:0] t, input logic [8:0] e);
        cmd_t c;
        c = '0;
        c.kind = KIND_READ;
        c.table_index = t;
        c.entry_index = e;
        c.virt_addr = {$urandom, $urandom};
        return c;
    endfunction

    // Random item: mostly maps into a few regions, some reads and broken items
    function automatic cmd_t random_cmd();
        cmd_t        c;
        logic [47:0] v;
        logic [51:0] p;
        logic [19:0] n;
        logic [15:0] fl;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return read_cmd(6'($urandom_range(tables_used + 2)), 9'($urandom));
        fl = ($urandom_range(99) < 80) ? 16'($urandom_range(4095)) : 16'($urandom);
        p = {$urandom, $urandom, 12'd0};
        if (pick < 38) begin
            v = {$urandom, $urandom};
            p[11:0] = 12'($urandom);
            if (v[11:0] == 0 && p[11:0] == 0)
                v[0] = 1'b1;
            return map_cmd(v, p, 20'($urandom), fl);
        end
        if ($urandom_range(99) < 75)
            v = region_base[$urandom_range(3)] | {25'd0, 11'($urandom), 12'd0};
        else
            v = {$urandom, $urandom, 12'd0};
        pick = $urandom_range(99);
        if (pick < 85)      n = 20'($urandom_range(4));
        else if (pick < 98) n = 20'($urandom_range(5, 40));
        else                n = 20'($urandom_range(513, 600));
        if (first_page_blocked(v) && $urandom_range(1))
            n = 20'($urandom);
        return map_cmd(v, p, n, fl);
    endfunction

    task automatic test_reads_after_reset();
        send_item(read_cmd(6'd0, 9'd0));
        send_item(read_cmd(6'd0, 9'd511));
        send_item(read_cmd(6'd63, 9'd511));
    endtask

    task automatic test_unaligned();
        send_item(map_cmd(48'h1, 52'h0, COUNT_MAX, 16'hFFFF));
        send_item(map_cmd(48'hFFFF_FFFF_F000, 52'h800, 20'd1, 16'h0));
        send_item(map_cmd(48'hFFF, 52'hFFF, 20'd0, 16'h0));
    endtask

    task automatic test_zero_count();
        send_item(map_cmd(48'h0, 52'h0, 20'd0, 16'h0FFF));
    endtask

    task automatic test_basic_and_wrap();
        send_item(map_cmd(48'h0, POOL_MAX & ~52'hFFF, 20'd1, 16'h0002));
        // both page addresses roll over at the top of their spaces
        send_item(map_cmd(48'hFFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000, 20'd2, 16'h0006));
        send_item(map_cmd(48'h0000_001F_E000, 52'h1234_5000, 20'd3, 16'h0800));
        send_item(read_cmd(6'd0, 9'd0));
        send_item(read_cmd(6'd0, 9'd511));
        send_item(read_cmd(6'd3, 9'd0));
        send_item(read_cmd(6'd3, 9'd511));
    endtask

    task automatic test_foreign_flags();
        // high flag bits corrupt the address field, so tables get replaced
        send_item(map_cmd(48'h0, 52'h5000, 20'd1, 16'hFFFF));
        send_item(map_cmd(48'h0000_0000_1000, 52'h6000, 20'd1, 16'h0000));
        send_item(read_cmd(6'd0, 9'd0));
        send_item(read_cmd(6'(tables_used - 1), 9'd1));
    endtask

    task automatic test_random(input int n, input int quiet_from, input int quiet_to);
        for (int i = 0; i < n; i++) begin
            gaps_on = !(i >= quiet_from && i < quiet_to);
            send_item(random_cmd());
        end
        gaps_on = 1;
    endtask

    task automatic test_exhaustion();
        logic [47:0] v;
        for (int i = 0; i < 25; i++)
            send_item(map_cmd({$urandom, $urandom, 12'd0}, {$urandom, $urandom, 12'd0},
                              20'd1, 16'($urandom_range(4095))));
        for (int i = 0; i < 4; i++) begin
            v = {$urandom, $urandom, 12'd0};
            if (first_page_blocked(v))
                send_item(map_cmd(v, {$urandom, $urandom, 12'd0}, COUNT_MAX, 16'hFFFF));
        end
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        gaps_on = 1;
        tables_used = 1;
        shadow_pool_base = '0;
        for (int i = 0; i < NUM_TABLES*TABLE_ENTRIES; i++)
            shadow_tables[i] = '0;
        for (int i = 0; i < 4; i++)
            region_base[i] = {$urandom, $urandom} & 48'hFFFF_C000_0000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_pool_base(POOL_MAX);
        test_reads_after_reset();
        test_unaligned();
        test_zero_count();
        test_basic_and_wrap();
        test_foreign_flags();
        test_random(450, -1, -1);
        set_pool_base('0);
        test_random(500, 0, 250);
        set_pool_base({$urandom, $urandom});
        test_exhaustion();
        test_random(320, -1, -1);

        // drain and let the block settle
        hold_off();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("four_level_page_table_mapper_unit_tb: PASS");
        else
            $display("four_level_page_table_mapper_unit_tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
